// ===== rtl/ccf_pkg.sv =====
`timescale 1ns / 1ps
package ccf_pkg;

   localparam int ATAN_LEN = 24;
   localparam int REG_COUNT = 5;

   typedef enum logic [2:0] {
      CSR_RADIUS = 3'd0,
      CSR_OFFSET = 3'd1,
      CSR_HEIGHT = 3'd2,
      CSR_GAIN   = 3'd3,
      CSR_MAX    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [15:0] quat_w;
      logic [15:0] quat_x;
      logic [15:0] quat_y;
      logic [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic [31:0] cam_x;
      logic [31:0] cam_y;
      logic [31:0] cam_z;
      logic [31:0] look_x;
      logic [31:0] look_y;
      logic [31:0] look_z;
      logic [2:0]  clamp_mask;
   } rsp_type;

   // datapath phase commands
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_MAT, OP_ATAN_INIT, OP_ATAN_STEP, OP_SC_INIT,
      OP_SC_STEP, OP_GOAL_MUL, OP_GOAL, OP_STEP_MUL, OP_STEP_ADD, OP_SET
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] iter;
      logic [1:0] axis;
   } cmd_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      logic signed [31:0] r;
      begin
         case (i)
            5'd0: r = 2949120;  5'd1: r = 1740967; 5'd2: r = 919879;
            5'd3: r = 466945;   5'd4: r = 234379;  5'd5: r = 117304;
            5'd6: r = 58666;    5'd7: r = 29335;   5'd8: r = 14668;
            5'd9: r = 7334;     5'd10: r = 3667;   5'd11: r = 1833;
            5'd12: r = 917;     5'd13: r = 458;    5'd14: r = 229;
            5'd15: r = 115;     5'd16: r = 57;     5'd17: r = 29;
            5'd18: r = 14;      5'd19: r = 7;      5'd20: r = 4;
            5'd21: r = 2;       5'd22: r = 1;      default: r = 0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/ccf_stream_if.sv =====
`timescale 1ns / 1ps
interface ccf_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/chase_camera_follow_step.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake           payload
// req      in   req_valid/req_ready mode, px..pz, quat_w..quat_z
// rsp      out  rsp_valid/rsp_ready cam_x..z, look_x..z, clamp_mask
// csr      in   csr_write           csr_index, csr_data
// follow request: runs the two cordic loops, which share one set of registers, then the
// per-axis multiply and add; set request: answered in the next cycle
// one request at a time; a result holds until rsp_ready
// reset (synchronous) clears camera position and loads register defaults
module chase_camera_follow_step #(
   parameter int FRAC_BITS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input logic         clock,
   input logic         reset,
   ccf_stream_if.sink  req,
   ccf_stream_if.source rsp,
   input logic         csr_write,
   input logic [2:0]   csr_index,
   input logic [31:0]  csr_data
);
   import ccf_pkg::*;

   cmd_type cmd;

   // sequencer
   ccf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_mode(req.payload.mode), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd(cmd)
   );

   // arithmetic and camera state
   ccf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req.payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp(rsp.payload)
   );

`ifndef NO_ASSERTIONS
   // never take a request while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("request taken with result pending");
   // a set request answers in the next cycle
   a_set_fast: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.payload.mode) |=> rsp.valid)
      else $error("set request not answered");
`endif
endmodule

// ===== rtl/ccf_ctrl.sv =====
`timescale 1ns / 1ps
module ccf_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_mode,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ccf_pkg::cmd_type   cmd
);
   import ccf_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam logic [4:0] LAST = 5'(NSTEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MAT, S_AINIT, S_ASTEP, S_SINIT, S_SSTEP, S_GMUL, S_GOAL,
      S_SMUL, S_SADD, S_OUT
   } state_type;

   state_type  state_ff;
   logic [4:0] iter_ff;
   logic [1:0] axis_ff;
   logic       rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.iter = iter_ff;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE:  cmd.op = (req_valid && req_ready) ?
                           (req_mode ? OP_SET : OP_LOAD) : OP_NONE;
         S_MAT:   cmd.op = OP_MAT;
         S_AINIT: cmd.op = OP_ATAN_INIT;
         S_ASTEP: cmd.op = OP_ATAN_STEP;
         S_SINIT: cmd.op = OP_SC_INIT;
         S_SSTEP: cmd.op = OP_SC_STEP;
         S_GMUL:  cmd.op = OP_GOAL_MUL;
         S_GOAL:  cmd.op = OP_GOAL;
         S_SMUL:  cmd.op = OP_STEP_MUL;
         S_SADD:  cmd.op = OP_STEP_ADD;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff <= '0;
         axis_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               if (req_mode) rsp_valid_ff <= 1'b1;
               else state_ff <= S_MAT;
            end
            S_MAT:   state_ff <= S_AINIT;
            S_AINIT: begin state_ff <= S_ASTEP; iter_ff <= '0; end
            S_ASTEP: begin
               if (iter_ff == LAST) state_ff <= S_SINIT;
               iter_ff <= iter_ff + 5'd1;
            end
            S_SINIT: begin state_ff <= S_SSTEP; iter_ff <= '0; end
            S_SSTEP: begin
               if (iter_ff == LAST) state_ff <= S_GMUL;
               iter_ff <= iter_ff + 5'd1;
            end
            S_GMUL:  state_ff <= S_GOAL;
            S_GOAL:  begin state_ff <= S_SMUL; axis_ff <= '0; end
            S_SMUL:  state_ff <= S_SADD;
            S_SADD: begin
               if (axis_ff == 2'd2) begin
                  state_ff <= S_OUT;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
                  state_ff <= S_SMUL;
               end
            end
            S_OUT: begin rsp_valid_ff <= 1'b1; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/ccf_datapath.sv =====
`timescale 1ns / 1ps
module ccf_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ccf_pkg::cmd_type cmd,
   input  ccf_pkg::req_type req,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data,
   output ccf_pkg::rsp_type rsp
);
   import ccf_pkg::*;

   localparam logic signed [47:0] ANG_90  = 48'sd5898240;
   localparam logic signed [47:0] ANG_180 = 48'sd11796480;
   localparam logic signed [47:0] ANG_360 = 48'sd23592960;

   // configuration
   logic        [30:0] radius_ff;
   logic signed [25:0] offset_ff;
   logic signed [31:0] height_ff;
   logic        [16:0] gain_ff;
   logic        [30:0] max_ff;

   // request payload, goal and camera state
   logic signed [31:0] p_ff [3];
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [31:0] cam_ff [3];
   logic signed [33:0] goal_ff [3];
   logic [2:0]         mask_ff;

   // cordic working set
   logic signed [47:0] cx_ff, cy_ff, cz_ff;
   logic               neg_ff;
   logic               zero_ff;
   logic signed [63:0] prod_ff [2];

   logic signed [47:0] ang_off;
   logic signed [47:0] a_norm;
   logic signed [47:0] xs, ys, at;
   logic signed [63:0] sum_ff;
   logic signed [34:0] d;
   logic signed [18:0] g;
   logic signed [63:0] v, vr;
   logic signed [63:0] maxs;
   logic signed [63:0] np;
   logic signed [63:0] mat8, mat10;
   logic signed [31:0] sin_q, cos_q;

   always_comb begin
      if (FRAC_BITS >= 16) ang_off = 48'(offset_ff) >>> (FRAC_BITS - 16);
      else ang_off = 48'(offset_ff) <<< (16 - FRAC_BITS);
      a_norm = cz_ff;
      if (a_norm > ANG_180) a_norm = a_norm - ANG_360;
      if (a_norm > ANG_180) a_norm = a_norm - ANG_360;
      if (a_norm <= -ANG_180) a_norm = a_norm + ANG_360;
      if (a_norm <= -ANG_180) a_norm = a_norm + ANG_360;
      xs = cx_ff >>> cmd.iter;
      ys = cy_ff >>> cmd.iter;
      at = 48'(atan_entry(cmd.iter));
      mat8 = sum_ff;
      mat10 = prod_ff[1];
      sin_q = 32'(neg_ff ? -cy_ff : cy_ff);
      cos_q = 32'(neg_ff ? -cx_ff : cx_ff);
      d = 35'(goal_ff[cmd.axis]) - 35'(cam_ff[cmd.axis]);
      g = (cmd.axis == 2'd1) ? 19'(gain_ff) : 19'({gain_ff, 1'b0});
      vr = (prod_ff[0] + 64'sd32768) >>> 16;
      maxs = 64'(max_ff);
      v = vr;
      if (vr > maxs) v = maxs;
      else if (vr < -maxs) v = -maxs;
      np = 64'(cam_ff[cmd.axis]) + v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 31'd786432;
         offset_ff <= '0;
         height_ff <= 32'sd262144;
         gain_ff <= 17'd3277;
         max_ff <= 31'd1310720;
         for (int k = 0; k < 3; k++) cam_ff[k] <= '0;
         mask_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_RADIUS: radius_ff <= csr_data[30:0];
               CSR_OFFSET: offset_ff <= csr_data[25:0];
               CSR_HEIGHT: height_ff <= csr_data;
               CSR_GAIN:   gain_ff <= csr_data[16:0];
               CSR_MAX:    max_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         case (cmd.op)
            OP_SET: begin
               p_ff[0] <= req.px; p_ff[1] <= req.py; p_ff[2] <= req.pz;
               cam_ff[0] <= req.px; cam_ff[1] <= req.py; cam_ff[2] <= req.pz;
               mask_ff <= '0;
            end
            OP_LOAD: begin
               p_ff[0] <= req.px; p_ff[1] <= req.py; p_ff[2] <= req.pz;
               qw_ff <= req.quat_w; qx_ff <= req.quat_x;
               qy_ff <= req.quat_y; qz_ff <= req.quat_z;
               mask_ff <= '0;
            end
            OP_MAT: begin
               // m8 in sum, m10 in prod[1]
               sum_ff <= 2 * (64'(qz_ff) * 64'(qx_ff) + 64'(qy_ff) * 64'(qw_ff));
               prod_ff[1] <= (64'sd1 <<< 28) -
                             2 * (64'(qy_ff) * 64'(qy_ff) + 64'(qx_ff) * 64'(qx_ff));
            end
            OP_ATAN_INIT: begin
               zero_ff <= (mat8 == 0 && mat10 == 0);
               if (mat8 == 0 && mat10 == 0) begin
                  cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
               end else if (mat10 < 0) begin
                  if (mat8 >= 0) begin
                     cx_ff <= 48'(mat8); cy_ff <= -48'(mat10); cz_ff <= ANG_90;
                  end else begin
                     cx_ff <= -48'(mat8); cy_ff <= 48'(mat10); cz_ff <= -ANG_90;
                  end
               end else begin
                  cx_ff <= 48'(mat10); cy_ff <= 48'(mat8); cz_ff <= '0;
               end
            end
            OP_ATAN_STEP: begin
               // both terms zero: yaw stays at zero
               if (!zero_ff) begin
                  if (cy_ff >= 0) begin
                     cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs; cz_ff <= cz_ff + at;
                  end else begin
                     cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs; cz_ff <= cz_ff - at;
                  end
               end
            end
            OP_SC_INIT: begin
               // angle = yaw + offset, folded into [-90, 90] on the first step
               cx_ff <= 48'sd652032875;
               cy_ff <= '0;
               cz_ff <= cz_ff + ang_off;
               neg_ff <= 1'b0;
            end
            OP_SC_STEP: begin
               if (cmd.iter == 5'd0) begin
                  // first step also does the quadrant fold
                  logic signed [47:0] a;
                  a = a_norm;
                  if (a > ANG_90) begin a = a - ANG_180; neg_ff <= 1'b1; end
                  else if (a < -ANG_90) begin a = a + ANG_180; neg_ff <= 1'b1; end
                  cx_ff <= (a >= 0) ? cx_ff - ys : cx_ff + ys;
                  cy_ff <= (a >= 0) ? cy_ff + xs : cy_ff - xs;
                  cz_ff <= (a >= 0) ? a - at : a + at;
               end else if (cz_ff >= 0) begin
                  cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs; cz_ff <= cz_ff - at;
               end else begin
                  cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs; cz_ff <= cz_ff + at;
               end
            end
            OP_GOAL_MUL: begin
               prod_ff[0] <= 64'(sin_q) * 64'(radius_ff);
               prod_ff[1] <= 64'(cos_q) * 64'(radius_ff);
            end
            OP_GOAL: begin
               goal_ff[0] <= 34'(64'(p_ff[0]) +
                                 ((prod_ff[0] + 64'sd536870912) >>> 30));
               goal_ff[1] <= 34'(64'(p_ff[1]) + 64'(height_ff));
               goal_ff[2] <= 34'(64'(p_ff[2]) +
                                 ((prod_ff[1] + 64'sd536870912) >>> 30));
            end
            OP_STEP_MUL: prod_ff[0] <= 64'(d) * 64'(g);
            OP_STEP_ADD: begin
               if (vr > maxs || vr < -maxs) mask_ff[cmd.axis] <= 1'b1;
               if (np > 64'sd2147483647) cam_ff[cmd.axis] <= 32'sh7fffffff;
               else if (np < -64'sd2147483648) cam_ff[cmd.axis] <= 32'sh80000000;
               else cam_ff[cmd.axis] <= 32'(np);
            end
            default: ;
         endcase
      end
   end

   assign rsp.cam_x = cam_ff[0];
   assign rsp.cam_y = cam_ff[1];
   assign rsp.cam_z = cam_ff[2];
   assign rsp.look_x = p_ff[0];
   assign rsp.look_y = p_ff[1];
   assign rsp.look_z = p_ff[2];
   assign rsp.clamp_mask = mask_ff;
endmodule
